>>> sv/sdrr_pkg.sv
// Shared types, constants and the digit segment table for the segment digit
// row renderer. No dependencies; imported by sdrr_row_mask and the top level.
`default_nettype none

package sdrr_pkg;

  // Largest box edge in pixels, and the fixed width of a row mask.
  localparam int MAX_BOX_DEF = 64;
  localparam int MASK_W      = 64;

  // Field widths.
  localparam int DIGIT_W  = 4;
  localparam int COORD_W  = 12;
  localparam int SIZE_W   = 7;
  localparam int RGB_W    = 24;
  localparam int C565_W   = 16;
  localparam int OFFS_W   = 26;
  localparam int STRIDE_W = 13;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE = 2'd2;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd640;
  localparam logic [DIGIT_W-1:0]  DIGIT_MAX    = 4'd9;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_LOAD,
    ST_SHOW
  } sdrr_state_t;

  // How a vertical segment covers the box rows.
  typedef enum logic [1:0] {
    SEG_OFF,
    SEG_FULL,
    SEG_UPPER,
    SEG_LOWER
  } seg_span_t;

  // Segments lit for one digit.
  typedef struct packed {
    logic      t;
    logic      b;
    logic      m;
    seg_span_t l;
    seg_span_t r;
  } seg_sel_t;

  // Segment table. Codes above nine fall on the nine row; the top level drops them.
  function automatic seg_sel_t digit_segments(input logic [DIGIT_W-1:0] dig);
    seg_sel_t s;
    case (dig)
      4'd0:    s = '{t: 1'b1, b: 1'b1, m: 1'b0, l: SEG_FULL,  r: SEG_FULL};
      4'd1:    s = '{t: 1'b0, b: 1'b0, m: 1'b0, l: SEG_FULL,  r: SEG_OFF};
      4'd2:    s = '{t: 1'b1, b: 1'b1, m: 1'b1, l: SEG_LOWER, r: SEG_UPPER};
      4'd3:    s = '{t: 1'b1, b: 1'b1, m: 1'b1, l: SEG_OFF,   r: SEG_FULL};
      4'd4:    s = '{t: 1'b0, b: 1'b0, m: 1'b1, l: SEG_UPPER, r: SEG_FULL};
      4'd5:    s = '{t: 1'b1, b: 1'b1, m: 1'b1, l: SEG_UPPER, r: SEG_LOWER};
      4'd6:    s = '{t: 1'b1, b: 1'b1, m: 1'b1, l: SEG_FULL,  r: SEG_LOWER};
      4'd7:    s = '{t: 1'b1, b: 1'b0, m: 1'b0, l: SEG_OFF,   r: SEG_FULL};
      4'd8:    s = '{t: 1'b1, b: 1'b1, m: 1'b1, l: SEG_FULL,  r: SEG_FULL};
      default: s = '{t: 1'b1, b: 1'b1, m: 1'b1, l: SEG_UPPER, r: SEG_FULL};
    endcase
    return s;
  endfunction

  // RGB888 to RGB565, keeping the top bits of each channel.
  function automatic logic [C565_W-1:0] to_565(input logic [RGB_W-1:0] c);
    return {c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage

`default_nettype wire

>>> sv/segment_digit_row_renderer_unit.sv
// Top level of the segment digit row renderer: command capture, row
// sequencer, offset arithmetic and output register. Uses sdrr_pkg, sdrr_row_mask.
`default_nettype none

// One draw request (digit, box corner, box size, colour) produces one result
// request per box row, top to bottom, each carrying the row's framebuffer pixel
// offset, the RGB565 colour and a mask of painted columns, with last_row set
// on the bottom row. The block takes one draw request at a time: in_stall is
// high from acceptance until the last row result has been taken. ST_CALC forms
// the first row's offset with a 13x13 multiplier; then each row passes through
// ST_LOAD, which loads the output register from the offset register, and
// ST_SHOW, which holds it while out_stall is high and hands it over. Requests
// with a digit above nine or a zero height are accepted and dropped without a
// result. Widths and heights above MAX_BOX are clipped to MAX_BOX.
module segment_digit_row_renderer_unit #(
  parameter int MAX_BOX = sdrr_pkg::MAX_BOX_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // draw requests
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [sdrr_pkg::DIGIT_W-1:0]        in_digit,
  input  wire logic [sdrr_pkg::COORD_W-1:0]        in_x_pos,
  input  wire logic [sdrr_pkg::COORD_W-1:0]        in_y_pos,
  input  wire logic [sdrr_pkg::SIZE_W-1:0]         in_box_width,
  input  wire logic [sdrr_pkg::SIZE_W-1:0]         in_box_height,
  input  wire logic [sdrr_pkg::RGB_W-1:0]          in_color_rgb,
  // row results
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [sdrr_pkg::OFFS_W-1:0]         out_pixel_offset,
  output logic      [sdrr_pkg::MASK_W-1:0]         out_row_mask,
  output logic      [sdrr_pkg::C565_W-1:0]         out_color565,
  output logic                                     out_last_row,
  // configuration writes
  input  wire logic                                cfg_wr_en,
  input  wire logic [sdrr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sdrr_pkg::STRIDE_W-1:0]       cfg_wdata
);
  import sdrr_pkg::*;

  localparam int CNT_W = $clog2(MAX_BOX);
  localparam logic [SIZE_W-1:0] BOX_LIMIT = SIZE_W'(MAX_BOX);

  // Configuration registers.
  logic [COORD_W-1:0]  x_offset_r;
  logic [COORD_W-1:0]  y_offset_r;
  logic [STRIDE_W-1:0] line_stride_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_offset_r    <= '0;
      y_offset_r    <= '0;
      line_stride_r <= STRIDE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_X_OFFSET:    x_offset_r    <= cfg_wdata[COORD_W-1:0];
        CFG_Y_OFFSET:    y_offset_r    <= cfg_wdata[COORD_W-1:0];
        CFG_LINE_STRIDE: line_stride_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  sdrr_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]    row_r, row_nxt;
  logic [DIGIT_W-1:0]  digit_r, digit_nxt;
  logic [SIZE_W-1:0]   width_r, width_nxt;
  logic [SIZE_W-1:0]   height_r, height_nxt;
  logic [C565_W-1:0]   color_r, color_nxt;
  logic [STRIDE_W-1:0] line_r, line_nxt;
  logic [STRIDE_W-1:0] xbase_r, xbase_nxt;
  logic [OFFS_W-1:0]   offset_r, offset_nxt;
  logic [OFFS_W-1:0]   out_offset_r, out_offset_nxt;
  logic [MASK_W-1:0]   out_mask_r, out_mask_nxt;
  logic                out_last_r, out_last_nxt;

  logic                in_take, out_take, row_is_last;
  logic [OFFS_W-1:0]   first_prod;
  logic [MASK_W-1:0]   row_mask;
  logic [SIZE_W-1:0]   width_sat, height_sat;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_SHOW);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  assign width_sat   = (in_box_width  > BOX_LIMIT) ? BOX_LIMIT : in_box_width;
  assign height_sat  = (in_box_height > BOX_LIMIT) ? BOX_LIMIT : in_box_height;
  assign row_is_last = (SIZE_W'(row_r) == height_r - SIZE_W'(1));
  assign first_prod  = line_r * line_stride_r;

  // Column mask for the row held in row_r.
  sdrr_row_mask #(
    .MAX_BOX (MAX_BOX)
  ) u_row_mask (
    .digit  (digit_r),
    .row    (row_r),
    .width  (width_r),
    .height (height_r),
    .mask   (row_mask)
  );

  // State register and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digit_r      <= digit_nxt;
    width_r      <= width_nxt;
    height_r     <= height_nxt;
    color_r      <= color_nxt;
    line_r       <= line_nxt;
    xbase_r      <= xbase_nxt;
    offset_r     <= offset_nxt;
    out_offset_r <= out_offset_nxt;
    out_mask_r   <= out_mask_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Next state: capture, first offset, then load and hand over each row.
  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    digit_nxt      = digit_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    color_nxt      = color_r;
    line_nxt       = line_r;
    xbase_nxt      = xbase_r;
    offset_nxt     = offset_r;
    out_offset_nxt = out_offset_r;
    out_mask_nxt   = out_mask_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          digit_nxt  = in_digit;
          width_nxt  = width_sat;
          height_nxt = height_sat;
          color_nxt  = to_565(in_color_rgb);
          line_nxt   = STRIDE_W'(in_y_pos) + STRIDE_W'(y_offset_r);
          xbase_nxt  = STRIDE_W'(in_x_pos) + STRIDE_W'(x_offset_r);
          row_nxt    = '0;
          if ((in_digit <= DIGIT_MAX) && (in_box_height != '0)) begin
            state_nxt = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        offset_nxt = first_prod + OFFS_W'(xbase_r);
        state_nxt  = ST_LOAD;
      end
      ST_LOAD: begin
        out_offset_nxt = offset_r;
        out_mask_nxt   = row_mask;
        out_last_nxt   = row_is_last;
        state_nxt      = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_take) begin
          if (out_last_r) begin
            row_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            offset_nxt = offset_r + OFFS_W'(line_stride_r);
            row_nxt    = row_r + CNT_W'(1);
            state_nxt  = ST_LOAD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_pixel_offset = out_offset_r;
  assign out_row_mask     = out_mask_r;
  assign out_color565     = color_r;
  assign out_last_row     = out_last_r;

`ifndef SYNTHESIS
  // A result is never offered while a new draw request can be taken.
  a_no_result_when_open: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("result offered while draw input is open");

  // Taking the bottom row frees the input on the next cycle.
  a_free_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && out_last_row |=> !in_stall)
    else $error("input not freed after last row");

  // Taking any other row brings the next row through ST_LOAD back to ST_SHOW.
  a_next_row_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && !out_last_row |=> ##1 out_valid)
    else $error("next row not presented");
`endif

endmodule

`default_nettype wire

>>> sv/sdrr_row_mask.sv
// Row mask generator: lit columns of one box row for a given digit.
// Depends on sdrr_pkg for the segment table and mask width.
`default_nettype none

module sdrr_row_mask #(
  parameter int MAX_BOX = sdrr_pkg::MAX_BOX_DEF,
  localparam int CNT_W  = $clog2(MAX_BOX)
) (
  input  wire logic [sdrr_pkg::DIGIT_W-1:0] digit,
  input  wire logic [CNT_W-1:0]             row,
  input  wire logic [sdrr_pkg::SIZE_W-1:0]  width,
  input  wire logic [sdrr_pkg::SIZE_W-1:0]  height,
  output logic      [sdrr_pkg::MASK_W-1:0]  mask
);
  import sdrr_pkg::*;

  seg_sel_t          seg;
  logic [SIZE_W-1:0] y;
  logic [SIZE_W-1:0] mid_row;
  logic              at_top, at_bot, at_mid, upper, lower;
  logic              l_on, r_on;
  logic [MASK_W-1:0] full, left_bit, right_bit;

  // Row position relative to the box.
  assign seg     = digit_segments(digit);
  assign y       = SIZE_W'(row);
  assign mid_row = height >> 1;
  assign at_top  = (y == '0);
  assign at_bot  = (y == height - SIZE_W'(1));
  assign at_mid  = (y == mid_row);
  assign upper   = (y <= mid_row);
  assign lower   = (y >= mid_row);

  // Resolve the half-height vertical segments.
  always_comb begin
    case (seg.l)
      SEG_FULL:  l_on = 1'b1;
      SEG_UPPER: l_on = upper;
      SEG_LOWER: l_on = lower;
      default:   l_on = 1'b0;
    endcase
    case (seg.r)
      SEG_FULL:  r_on = 1'b1;
      SEG_UPPER: r_on = upper;
      SEG_LOWER: r_on = lower;
      default:   r_on = 1'b0;
    endcase
  end

  // Column patterns for a horizontal bar and for the left and right edges.
  assign full      = {MASK_W{1'b1}} >> (SIZE_W'(MASK_W) - width);
  assign left_bit  = MASK_W'(1);
  assign right_bit = MASK_W'(1) << (width - SIZE_W'(1));

  // A zero-width box paints nothing.
  always_comb begin
    mask = '0;
    if (width != '0) begin
      if ((seg.t && at_top) || (seg.b && at_bot) || (seg.m && at_mid)) begin
        mask = full;
      end
      if (l_on) begin
        mask = mask | left_bit;
      end
      if (r_on) begin
        mask = mask | right_bit;
      end
    end
  end

endmodule

`default_nettype wire
